// File: design/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants and types for the 4x4 perspective point transform.
// ----------------------------------------------------------------------------
package ptp_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int IO_W      = 32;
   localparam int COEF_W    = 32;
   localparam int CSR_W     = 64;
   localparam int CSR_NUM   = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_COL_X_A = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_X_B = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_Y_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_Y_B = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_Z_A = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_Z_B = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_W_A = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_W_B = CSR_IDX_W'(7);

   localparam logic MODE_POINT  = 1'b0;
   localparam logic MODE_NORMAL = 1'b1;

   typedef struct packed {
      logic neg;
      logic ovf;
   } lane_ctl_type;

endpackage

// File: design/ptp_if.sv
// ----------------------------------------------------------------------------
// ptp request / response channels
// Valid/ready channels carrying the transform request and its result.
// ----------------------------------------------------------------------------
interface ptp_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;

   modport source (output valid, mode, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, pos_z, output ready);
endinterface

interface ptp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic        divide_by_zero;
   logic        saturated;

   modport source (output valid, out_x, out_y, out_z, divide_by_zero, saturated,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, divide_by_zero, saturated,
                   output ready);
endinterface

// File: design/ptp_row.sv
// ----------------------------------------------------------------------------
// ptp_row
// One matrix row: three coefficient products, then their sum with translation.
// ----------------------------------------------------------------------------
module ptp_row #(
   parameter int COORD_BITS = ptp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ptp_pkg::FRAC_BITS_DEF,
   parameter int SUM_W      = 66
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [COORD_BITS-1:0]   px,
   input  logic signed [COORD_BITS-1:0]   py,
   input  logic signed [COORD_BITS-1:0]   pz,
   input  logic        [ptp_pkg::CSR_W-1:0] coef_a,
   input  logic        [ptp_pkg::CSR_W-1:0] coef_b,
   input  logic                           point,
   output logic signed [SUM_W-1:0]        sum
);
   import ptp_pkg::*;

   localparam int FULL_W = COORD_BITS + COEF_W;
   localparam int PROD_W = FULL_W - FRAC_BITS;

   logic signed [COEF_W-1:0] c0, c1, c2, tr_in;
   logic signed [FULL_W-1:0] f0, f1, f2;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [COEF_W-1:0] tr_ff;
   logic signed [SUM_W-1:0]  sum_in, sum_ff;

   always_comb begin
      c0    = signed'(coef_a[COEF_W-1:0]);
      c1    = signed'(coef_a[CSR_W-1:COEF_W]);
      c2    = signed'(coef_b[COEF_W-1:0]);
      tr_in = point ? signed'(coef_b[CSR_W-1:COEF_W]) : '0;
      f0    = px * c0;
      f1    = py * c1;
      f2    = pz * c2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= PROD_W'(f0 >>> FRAC_BITS);
         p1_ff <= PROD_W'(f1 >>> FRAC_BITS);
         p2_ff <= PROD_W'(f2 >>> FRAC_BITS);
         tr_ff <= tr_in;
      end
   end

   assign sum_in = SUM_W'(p0_ff) + SUM_W'(p1_ff) + SUM_W'(p2_ff) + SUM_W'(tr_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: design/ptp_div.sv
// ----------------------------------------------------------------------------
// ptp_div
// Pipelined restoring divider, one quotient bit per stage, for one lane.
// ----------------------------------------------------------------------------
module ptp_div #(
   parameter int COORD_BITS = ptp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ptp_pkg::FRAC_BITS_DEF,
   parameter int SUM_W      = 66
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [SUM_W-1:0]          num_mag,
   input  logic [SUM_W-1:0]          den,
   input  ptp_pkg::lane_ctl_type     ctl,
   output logic [COORD_BITS-1:0]     quo,
   output ptp_pkg::lane_ctl_type     ctl_out
);
   import ptp_pkg::*;

   localparam int NW = SUM_W + FRAC_BITS;

   logic [NW-1:0]         num_ext;
   logic [NW-1:0]         num_hi;
   logic [SUM_W-1:0]      rem_ff [COORD_BITS];
   logic [COORD_BITS-1:0] quo_ff [COORD_BITS];
   logic [COORD_BITS-1:0] low_ff [COORD_BITS];
   logic [SUM_W-1:0]      den_ff [COORD_BITS];
   lane_ctl_type          ctl_ff [COORD_BITS];

   assign num_ext = {num_mag, {FRAC_BITS{1'b0}}};
   assign num_hi  = num_ext >> COORD_BITS;

   for (genvar s = 0; s < COORD_BITS; s++) begin : g_stage
      logic [SUM_W-1:0]      rem_prev;
      logic [COORD_BITS-1:0] quo_prev;
      logic [COORD_BITS-1:0] low_prev;
      logic [SUM_W-1:0]      den_prev;
      lane_ctl_type          ctl_prev;
      logic [SUM_W:0]        trial;
      logic                  fits;
      logic [SUM_W:0]        diff;

      if (s == 0) begin : g_first
         assign rem_prev = num_hi[SUM_W-1:0];
         assign quo_prev = '0;
         assign low_prev = num_ext[COORD_BITS-1:0];
         assign den_prev = den;
         assign ctl_prev = ctl;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign quo_prev = quo_ff[s-1];
         assign low_prev = low_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign ctl_prev = ctl_ff[s-1];
      end

      always_comb begin
         trial = {rem_prev, low_prev[COORD_BITS-1]};
         fits  = trial >= {1'b0, den_prev};
         diff  = trial - {1'b0, den_prev};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            quo_ff[s] <= {quo_prev[COORD_BITS-2:0], fits};
            low_ff[s] <= low_prev << 1;
            den_ff[s] <= den_prev;
            ctl_ff[s] <= ctl_prev;
         end
      end
   end

   assign quo     = quo_ff[COORD_BITS-1];
   assign ctl_out = ctl_ff[COORD_BITS-1];

endmodule

// File: design/point_transform_4x4_perspective.sv
// Registers in order: products, sums, divisor select, divider stages, output.
// Throughput: one request per cycle unless a held result stalls the pipeline;
// the divider retires one quotient bit per stage, so its depth sets the latency.
// Reset: synchronous, active high; clears valid bits and loads the identity
// matrix into the column registers.
// ----------------------------------------------------------------------------
// point_transform_4x4_perspective
// Homogeneous 4x4 vertex transform with perspective divide, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module point_transform_4x4_perspective #(
   parameter int COORD_BITS = ptp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ptp_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ptp_req_if.sink                        req_ch,
   ptp_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [ptp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptp_pkg::CSR_W-1:0]      csr_wdata
);
   import ptp_pkg::*;

   localparam int PROD_W = COORD_BITS + COEF_W - FRAC_BITS;
   localparam int SUM_W  = ((PROD_W > COEF_W) ? PROD_W : COEF_W) + 2;
   localparam int WIDE_W = SUM_W + FRAC_BITS + COORD_BITS;
   localparam int LAT    = 3 + COORD_BITS;
   localparam logic [CSR_W-1:0] ONE_LO = CSR_W'(1) << FRAC_BITS;
   localparam logic [CSR_W-1:0] ONE_HI = CSR_W'(1) << (COEF_W + FRAC_BITS);
   localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic [CSR_W-1:0] cfg_ff [CSR_NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= ONE_LO;
         cfg_ff[1] <= '0;
         cfg_ff[2] <= ONE_HI;
         cfg_ff[3] <= '0;
         cfg_ff[4] <= '0;
         cfg_ff[5] <= ONE_LO;
         cfg_ff[6] <= '0;
         cfg_ff[7] <= ONE_HI;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COL_X_A: cfg_ff[0] <= csr_wdata;
            CSR_COL_X_B: cfg_ff[1] <= csr_wdata;
            CSR_COL_Y_A: cfg_ff[2] <= csr_wdata;
            CSR_COL_Y_B: cfg_ff[3] <= csr_wdata;
            CSR_COL_Z_A: cfg_ff[4] <= csr_wdata;
            CSR_COL_Z_B: cfg_ff[5] <= csr_wdata;
            CSR_COL_W_A: cfg_ff[6] <= csr_wdata;
            CSR_COL_W_B: cfg_ff[7] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [LAT-1:0] vld_ff;
   logic           out_vld_ff;
   logic           out_load;
   logic           en;

   assign out_load     = !out_vld_ff || rsp_ch.ready;
   assign en           = !vld_ff[LAT-1] || out_load;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
         end
         if (out_load) begin
            out_vld_ff <= vld_ff[LAT-1];
         end
      end
   end

   // multiply and sum
   logic signed [COORD_BITS-1:0] px, py, pz;
   logic                         point_in;
   logic signed [SUM_W-1:0]      sum [4];
   logic [1:0]                   point_ff;

   assign px       = signed'(req_ch.pos_x[COORD_BITS-1:0]);
   assign py       = signed'(req_ch.pos_y[COORD_BITS-1:0]);
   assign pz       = signed'(req_ch.pos_z[COORD_BITS-1:0]);
   assign point_in = (req_ch.mode == MODE_POINT);

   for (genvar r = 0; r < 4; r++) begin : g_row
      ptp_row #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .SUM_W      (SUM_W)
      ) u_row (
         .clock  (clock),
         .en     (en),
         .px     (px),
         .py     (py),
         .pz     (pz),
         .coef_a (cfg_ff[2*r]),
         .coef_b (cfg_ff[2*r+1]),
         .point  (point_in),
         .sum    (sum[r])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         point_ff <= {point_ff[0], point_in};
      end
   end

   // divisor selection and overflow check
   logic [SUM_W-1:0]  num_in [3];
   logic [SUM_W-1:0]  den_in [3];
   lane_ctl_type      ctl_in [3];
   logic              dz_in;
   logic [SUM_W-1:0]  num_ff [3];
   logic [SUM_W-1:0]  den_ff [3];
   lane_ctl_type      ctl_ff [3];
   logic [COORD_BITS:0] dz_ff;

   always_comb begin
      logic             pt;
      logic             w_neg;
      logic [SUM_W-1:0] w_mag;
      logic             n_neg;
      logic [SUM_W-1:0] den_sel;
      logic [WIDE_W-1:0] ext_n;
      logic [WIDE_W-1:0] ext_d;
      pt      = point_ff[1];
      w_neg   = sum[3][SUM_W-1];
      w_mag   = w_neg ? SUM_W'(-sum[3]) : SUM_W'(sum[3]);
      dz_in   = pt && (sum[3] == '0);
      den_sel = !pt ? (SUM_W'(1) << FRAC_BITS) : (dz_in ? SUM_W'(1) : w_mag);
      for (int k = 0; k < 3; k++) begin
         n_neg     = sum[k][SUM_W-1];
         num_in[k] = n_neg ? SUM_W'(-sum[k]) : SUM_W'(sum[k]);
         den_in[k] = den_sel;
         ext_n     = WIDE_W'(num_in[k]) << FRAC_BITS;
         ext_d     = WIDE_W'(den_sel) << COORD_BITS;
         ctl_in[k].neg = n_neg ^ (pt && w_neg);
         ctl_in[k].ovf = dz_in ? (sum[k] != '0) : (ext_n >= ext_d);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
         ctl_ff <= ctl_in;
         dz_ff  <= {dz_ff[COORD_BITS-1:0], dz_in};
      end
   end

   // division lanes
   logic [COORD_BITS-1:0] quo [3];
   lane_ctl_type          qctl [3];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      ptp_div #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .SUM_W      (SUM_W)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .num_mag (num_ff[k]),
         .den     (den_ff[k]),
         .ctl     (ctl_ff[k]),
         .quo     (quo[k]),
         .ctl_out (qctl[k])
      );
   end

   // clip and output register
   logic [IO_W-1:0] res_in [3];
   logic            sat_in;
   logic [IO_W-1:0] res_ff [3];
   logic            sat_ff;
   logic            dzo_ff;

   always_comb begin
      logic                         clip;
      logic signed [COORD_BITS-1:0] val;
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (qctl[k].neg) begin
            clip = qctl[k].ovf || (quo[k] > MINV);
            val  = clip ? signed'(MINV) : signed'(-quo[k]);
         end else begin
            clip = qctl[k].ovf || (quo[k] > MAXV);
            val  = clip ? signed'(MAXV) : signed'(quo[k]);
         end
         sat_in    = sat_in | clip;
         res_in[k] = IO_W'(val);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
         dzo_ff <= dz_ff[COORD_BITS];
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.out_x          = res_ff[0];
   assign rsp_ch.out_y          = res_ff[1];
   assign rsp_ch.out_z          = res_ff[2];
   assign rsp_ch.divide_by_zero = dzo_ff;
   assign rsp_ch.saturated      = sat_ff;

`ifndef ASSERT_OFF
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("request stalled while result side free");

   a_dz_unsat_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.divide_by_zero && !rsp_ch.saturated) |->
      (rsp_ch.out_x == '0 && rsp_ch.out_y == '0 && rsp_ch.out_z == '0))
      else $error("zero divisor without clipping gave nonzero result");

   a_dz_x_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.divide_by_zero && rsp_ch.out_x != '0) |->
      (rsp_ch.out_x == IO_W'(signed'(MAXV)) || rsp_ch.out_x == IO_W'(signed'(MINV))))
      else $error("zero divisor gave unsaturated x");
`endif

endmodule

// File: test/ptp_checker.sv
// ----------------------------------------------------------------------------
// ptp_checker
// Watches the request, result and column register ports of the perspective
// point transform, predicts each result from its own copy of the matrix and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptp_checker (
   input  logic                          clock,
   input  logic                          reset,
   ptp_req_if                            req,
   ptp_rsp_if                            rsp,
   input  logic                          csr_we,
   input  logic [ptp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptp_pkg::CSR_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   import ptp_pkg::*;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        dz;
      logic        sat;
   } vertex_out_type;

   logic [CSR_W-1:0] columns [CSR_NUM];
   vertex_out_type   vertex_q [$];

   localparam logic signed [127:0] MAX_OUT = 128'sd2147483647;
   localparam logic signed [127:0] MIN_OUT = -128'sd2147483648;

   function automatic longint coef(input int reg_idx, input bit hi);
      logic [31:0] half;
      half = hi ? columns[reg_idx][63:32] : columns[reg_idx][31:0];
      return longint'(signed'(half));
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b) >>> FRAC_BITS_DEF;
   endfunction

   function automatic longint dot_row(input int row, input longint px, input longint py,
                                      input longint pz, input bit point);
      longint acc;
      acc = fx_mul(px, coef(2 * row, 0)) + fx_mul(py, coef(2 * row, 1))
          + fx_mul(pz, coef(2 * row + 1, 0));
      if (point) acc += coef(2 * row + 1, 1);
      return acc;
   endfunction

   function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic flag);
      if (v > MAX_OUT) begin
         flag = 1'b1;
         return 32'h7fff_ffff;
      end
      if (v < MIN_OUT) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic vertex_out_type transform_vertex(input logic mode,
                                                       input logic [31:0] x,
                                                       input logic [31:0] y,
                                                       input logic [31:0] z);
      vertex_out_type         r;
      longint                 px, py, pz, w, n;
      logic signed [127:0]    num;
      logic [31:0]            comp [3];
      bit                     point;
      point = (mode == MODE_POINT);
      px = longint'(signed'(x));
      py = longint'(signed'(y));
      pz = longint'(signed'(z));
      r.sat = 1'b0;
      r.dz = 1'b0;
      w = dot_row(3, px, py, pz, 1);
      if (point && w == 0) r.dz = 1'b1;
      for (int k = 0; k < 3; k++) begin
         n = dot_row(k, px, py, pz, point);
         if (!point) comp[k] = clamp(128'(signed'(n)), r.sat);
         else if (r.dz) comp[k] = (n == 0) ? 32'h0 : clamp(n > 0 ? MAX_OUT + 1 : MIN_OUT - 1,
                                                           r.sat);
         else begin
            num = 128'(signed'(n)) <<< FRAC_BITS_DEF;
            comp[k] = clamp(num / 128'(signed'(w)), r.sat);
         end
      end
      r.x = comp[0];
      r.y = comp[1];
      r.z = comp[2];
      return r;
   endfunction

   assign pending = vertex_q.size();

   always @(posedge clock) begin
      vertex_out_type exp_v;
      if (reset) begin
         columns[0] = 64'h0000_0000_0001_0000;
         columns[1] = 64'h0;
         columns[2] = 64'h0001_0000_0000_0000;
         columns[3] = 64'h0;
         columns[4] = 64'h0;
         columns[5] = 64'h0000_0000_0001_0000;
         columns[6] = 64'h0;
         columns[7] = 64'h0001_0000_0000_0000;
         vertex_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (vertex_q.size() == 0) begin
               $error("result with no request outstanding: x=%h", rsp.out_x);
               fail_count++;
            end else begin
               exp_v = vertex_q.pop_front();
               if (rsp.out_x !== exp_v.x) begin
                  $error("out_x exp %h got %h", exp_v.x, rsp.out_x);
                  fail_count++;
               end
               if (rsp.out_y !== exp_v.y) begin
                  $error("out_y exp %h got %h", exp_v.y, rsp.out_y);
                  fail_count++;
               end
               if (rsp.out_z !== exp_v.z) begin
                  $error("out_z exp %h got %h", exp_v.z, rsp.out_z);
                  fail_count++;
               end
               if (rsp.divide_by_zero !== exp_v.dz) begin
                  $error("divide_by_zero exp %b got %b", exp_v.dz, rsp.divide_by_zero);
                  fail_count++;
               end
               if (rsp.saturated !== exp_v.sat) begin
                  $error("saturated exp %b got %b", exp_v.sat, rsp.saturated);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            vertex_q.push_back(transform_vertex(req.mode, req.pos_x, req.pos_y, req.pos_z));
         if (csr_we && csr_index < CSR_NUM) columns[csr_index[2:0]] = csr_wdata;
      end
   end

   initial fail_count = 0;
endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the perspective point transform with directed corner vertices and
// random vertex streams under several matrices, with bursty requests and a
// stalling result sink; ptp_checker predicts and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import ptp_pkg::*;

   localparam int LATENCY = 36;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   pending;
   bit                   long_hold;
   int                   burst_left;

   ptp_req_if req ();
   ptp_rsp_if rsp ();

   point_transform_4x4_perspective u_top (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ptp_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // result sink: changing stall pattern plus one long hold on request
   initial begin
      int style;
      rsp.ready = 1'b0;
      style = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) style = $urandom_range(0, 3);
            case (style)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= $urandom_range(0, 1);
               2: rsp.ready <= ($urandom_range(0, 7) == 0);
               default: rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
         2: case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         default: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'h0;
         default: return 32'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
      endcase
   endfunction

   // let the checker log the last request before waiting for the pipeline to drain
   task automatic idle_wait();
      req.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic load_matrix(input logic [CSR_W-1:0] cols [CSR_NUM]);
      idle_wait();
      for (int i = 0; i < CSR_NUM; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= cols[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push(input logic mode, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] z);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.mode  <= mode;
      req.pos_x <= x;
      req.pos_y <= y;
      req.pos_z <= z;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   initial begin
      logic [CSR_W-1:0] cols [CSR_NUM];
      logic [31:0]      corner [4];
      int               kind;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req.valid  = 1'b0;
      req.mode   = MODE_POINT;
      req.pos_x  = '0;
      req.pos_y  = '0;
      req.pos_z  = '0;
      long_hold  = 1'b0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix: corner coordinates in both modes
      corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
      for (int i = 0; i < 4; i++) begin
         push(MODE_POINT, corner[i], corner[3 - i], corner[(i + 1) % 4]);
         push(MODE_NORMAL, corner[i], corner[(i + 2) % 4], corner[3 - i]);
      end

      // zero w row: divide by zero with positive, negative and zero numerators
      cols = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
               64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0};
      load_matrix(cols);
      push(MODE_POINT, 32'h0001_0000, 32'hffff_0000, 32'h0);
      push(MODE_POINT, 32'h0, 32'h0, 32'h0);
      push(MODE_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h0002_0000);
      push(MODE_NORMAL, 32'h8000_0000, 32'h7fff_ffff, 32'h0002_0000);

      // scale by 4 with tiny w: saturation on x and y of a point, on every lane in normal mode
      cols = '{64'h0000_0000_0004_0000, 64'h0, 64'h0004_0000_0000_0000, 64'h0,
               64'h0, 64'h0000_0000_0004_0000, 64'h0, 64'h0000_0001_0000_0000};
      load_matrix(cols);
      push(MODE_POINT, 32'h0010_0000, 32'hfff0_0000, 32'h0000_0001);
      push(MODE_NORMAL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      push(MODE_POINT, 32'h0, 32'h0, 32'h0);

      for (int phase = 0; phase < 9; phase++) begin
         kind = (phase < 6) ? phase : $urandom_range(0, 5);
         for (int i = 0; i < CSR_NUM; i++) begin
            case (kind)
               0: cols[i] = {rand_coef(), rand_coef()};
               1: cols[i] = {$urandom, $urandom};
               2: cols[i] = 64'h8000_0000_8000_0000;
               3: cols[i] = 64'h7fff_ffff_7fff_ffff;
               4: cols[i] = (i >= 6) ? 64'h0 : {rand_coef(), rand_coef()};
               default: cols[i] = {rand_coef(), rand_coef()} & 64'h000f_ffff_000f_ffff;
            endcase
         end
         if (kind == 0 || kind == 5) cols[7][63:32] = 32'h0001_0000;
         load_matrix(cols);
         for (int n = 0; n < 130; n++) begin
            if (phase == 2 && n == 20) long_hold = 1'b1;
            push(logic'($urandom_range(0, 3) == 0), rand_coord(), rand_coord(), rand_coord());
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
